[design/free_range_suballocator_assert.svh]
// ----------------------------------------------------------------------------
// Free range suballocator assertion macros
// Shared property wrappers for the concurrent checks in the design.
// ----------------------------------------------------------------------------
`ifndef FREE_RANGE_SUBALLOCATOR_ASSERT_SVH
`define FREE_RANGE_SUBALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frsa: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FRSA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("frsa: next-cycle check failed");

`endif

[design/frsa_pkg.sv]
// ----------------------------------------------------------------------------
// frsa_pkg
// Shared constants, types and command codes of the free range suballocator.
// ----------------------------------------------------------------------------
package frsa_pkg;

  localparam int MAX_RANGES = 64;
  localparam int OFS_W      = 32;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int ALIGN_W    = 5;
  localparam int STATUS_W   = 2;
  localparam logic [OFS_W-1:0] CHUNK_RESET = 32'd16777216;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOMEM    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] len;
  } range_t;

  // Datapath commands, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_AL_RD,
    OP_AL_EV1,
    OP_AL_EV2,
    OP_SP_A,
    OP_SP_B,
    OP_SP_C,
    OP_SP_WR,
    OP_NOFIT,
    OP_INS_SET,
    OP_INS_RD,
    OP_INS_MV,
    OP_INS_WR,
    OP_RM_SET,
    OP_RM_RD,
    OP_RM_MV,
    OP_FR_RD,
    OP_FR_CMP,
    OP_FR_LRD,
    OP_FR_LEV,
    OP_FR_RRD,
    OP_FR_REV,
    OP_FR_ADJR,
    OP_FR_ML,
    OP_FR_MR,
    OP_FR_MW,
    OP_FIN_RD,
    OP_FIN_EV,
    OP_PUSH
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_AL_CHK,
    S_AL_EV1,
    S_AL_EV2,
    S_SP_A,
    S_SP_B,
    S_SP_C,
    S_SP_WR,
    S_NOFIT,
    S_INS_SET,
    S_INS_CHK,
    S_INS_MV,
    S_INS_WR,
    S_RM_SET,
    S_RM_CHK,
    S_RM_MV,
    S_FR_CHK,
    S_FR_CMP,
    S_FR_L,
    S_FR_LE,
    S_FR_R,
    S_FR_RE,
    S_FR_ACT,
    S_FR_ML,
    S_FR_MR,
    S_FR_MW,
    S_FIN,
    S_FIN_E,
    S_DONE
  } state_e;

  // Datapath status seen by the controller
  typedef struct packed {
    logic is_free;
    logic scan_end;
    logic found;
    logic fit_exact;
    logic l_nz;
    logic r_nz;
    logic full;
    logic ins_more;
    logic rm_more;
    logic srch_open;
    logic has_left;
    logic has_right;
    logic adj_l;
    logic adj_r;
    logic count_one;
    logic out_free;
  } sts_t;

endpackage

[design/free_range_suballocator.sv]
// ----------------------------------------------------------------------------
// free_range_suballocator
// Sorted free-range table for one memory chunk with allocate and coalescing free.
// ----------------------------------------------------------------------------
//  Port group   Dir   Role
//  s_axis_*     in    requests: allocate or free
//  m_axis_*     out   one result per request
//  APB (p*)     in    chunk_size register at byte address 0
//
// An allocate walks the stored ranges one by one, then splits the chosen
// range; a free does a binary search. Inserting or removing a range moves
// each later entry in turn, all through the table memory. One request is
// in work at a time; a finished result sits in the output register while
// the next request is taken.
// Reset or a chunk_size write leaves one free range [0, chunk_size).
// ----------------------------------------------------------------------------
module free_range_suballocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request_size [31:0], align_log2 [36:32], free_offset [68:37], zero pad
  input  logic [71:0] s_axis_tdata,
  // func [0]: allocate or free
  input  logic [0:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status [1:0], alloc_offset [33:2], chunk_empty [34], zero pad
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  frsa_pkg::op_e  op;
  frsa_pkg::sts_t sts;
  logic [frsa_pkg::OFS_W-1:0]    chunk;
  logic [frsa_pkg::STATUS_W-1:0] out_status;
  logic [frsa_pkg::OFS_W-1:0]    out_offset;
  logic                          out_empty;
  logic                          cfg_we;

  // write chunk_size at the access phase; other addresses hold nothing
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? chunk : 32'd0;

  frsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .op_o       (op)
  );

  frsa_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .sts_o        (sts),
    .func_i       (s_axis_tuser[0]),
    .size_i       (s_axis_tdata[31:0]),
    .align_i      (s_axis_tdata[36:32]),
    .offset_i     (s_axis_tdata[68:37]),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (pwdata),
    .chunk_o      (chunk),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_offset_o (out_offset),
    .out_empty_o  (out_empty)
  );

  assign m_axis_tdata = {5'd0, out_empty, out_offset, out_status};

endmodule

[design/frsa_ctrl.sv]
// ----------------------------------------------------------------------------
// frsa_ctrl
// Request sequencer: walks the scan, split, shift, search and merge steps.
// ----------------------------------------------------------------------------
module frsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  frsa_pkg::sts_t sts_i,
  output frsa_pkg::op_e  op_o
);

  frsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frsa_pkg::S_IDLE:    if (in_valid_i) state_d = frsa_pkg::S_DISP;
      frsa_pkg::S_DISP:    state_d = sts_i.is_free ? frsa_pkg::S_FR_CHK : frsa_pkg::S_AL_CHK;
      frsa_pkg::S_AL_CHK: begin
        if (!sts_i.scan_end) state_d = frsa_pkg::S_AL_EV1;
        else if (sts_i.found) state_d = frsa_pkg::S_SP_A;
        else state_d = frsa_pkg::S_NOFIT;
      end
      frsa_pkg::S_AL_EV1:  state_d = frsa_pkg::S_AL_EV2;
      frsa_pkg::S_AL_EV2:  state_d = sts_i.fit_exact ? frsa_pkg::S_SP_A : frsa_pkg::S_AL_CHK;
      frsa_pkg::S_SP_A:    state_d = frsa_pkg::S_SP_B;
      frsa_pkg::S_SP_B:    state_d = frsa_pkg::S_SP_C;
      frsa_pkg::S_SP_C:    state_d = frsa_pkg::S_SP_WR;
      frsa_pkg::S_SP_WR: begin
        if (sts_i.l_nz && sts_i.r_nz) state_d = frsa_pkg::S_INS_SET;
        else if (!sts_i.l_nz && !sts_i.r_nz) state_d = frsa_pkg::S_RM_SET;
        else state_d = frsa_pkg::S_FIN;
      end
      frsa_pkg::S_NOFIT:   state_d = frsa_pkg::S_FIN;
      frsa_pkg::S_INS_SET: state_d = sts_i.full ? frsa_pkg::S_FIN : frsa_pkg::S_INS_CHK;
      frsa_pkg::S_INS_CHK: state_d = sts_i.ins_more ? frsa_pkg::S_INS_MV : frsa_pkg::S_INS_WR;
      frsa_pkg::S_INS_MV:  state_d = frsa_pkg::S_INS_CHK;
      frsa_pkg::S_INS_WR:  state_d = frsa_pkg::S_FIN;
      frsa_pkg::S_RM_SET:  state_d = frsa_pkg::S_RM_CHK;
      frsa_pkg::S_RM_CHK:  state_d = sts_i.rm_more ? frsa_pkg::S_RM_MV : frsa_pkg::S_FIN;
      frsa_pkg::S_RM_MV:   state_d = frsa_pkg::S_RM_CHK;
      frsa_pkg::S_FR_CHK:  state_d = sts_i.srch_open ? frsa_pkg::S_FR_CMP : frsa_pkg::S_FR_L;
      frsa_pkg::S_FR_CMP:  state_d = frsa_pkg::S_FR_CHK;
      frsa_pkg::S_FR_L:    state_d = sts_i.has_left ? frsa_pkg::S_FR_LE : frsa_pkg::S_FR_R;
      frsa_pkg::S_FR_LE:   state_d = frsa_pkg::S_FR_R;
      frsa_pkg::S_FR_R:    state_d = sts_i.has_right ? frsa_pkg::S_FR_RE : frsa_pkg::S_FR_ACT;
      frsa_pkg::S_FR_RE:   state_d = frsa_pkg::S_FR_ACT;
      frsa_pkg::S_FR_ACT: begin
        if (sts_i.adj_l) state_d = frsa_pkg::S_FR_ML;
        else if (sts_i.adj_r) state_d = frsa_pkg::S_FIN;
        else state_d = frsa_pkg::S_INS_SET;
      end
      frsa_pkg::S_FR_ML:   state_d = frsa_pkg::S_FR_MR;
      frsa_pkg::S_FR_MR:   state_d = frsa_pkg::S_FR_MW;
      frsa_pkg::S_FR_MW:   state_d = sts_i.adj_r ? frsa_pkg::S_RM_SET : frsa_pkg::S_FIN;
      frsa_pkg::S_FIN:     state_d = sts_i.count_one ? frsa_pkg::S_FIN_E : frsa_pkg::S_DONE;
      frsa_pkg::S_FIN_E:   state_d = frsa_pkg::S_DONE;
      frsa_pkg::S_DONE:    if (sts_i.out_free) state_d = frsa_pkg::S_IDLE;
      default:             state_d = frsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_o       = frsa_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      frsa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = frsa_pkg::OP_LATCH;
      end
      frsa_pkg::S_AL_CHK:  if (!sts_i.scan_end) op_o = frsa_pkg::OP_AL_RD;
      frsa_pkg::S_AL_EV1:  op_o = frsa_pkg::OP_AL_EV1;
      frsa_pkg::S_AL_EV2:  op_o = frsa_pkg::OP_AL_EV2;
      frsa_pkg::S_SP_A:    op_o = frsa_pkg::OP_SP_A;
      frsa_pkg::S_SP_B:    op_o = frsa_pkg::OP_SP_B;
      frsa_pkg::S_SP_C:    op_o = frsa_pkg::OP_SP_C;
      frsa_pkg::S_SP_WR:   op_o = frsa_pkg::OP_SP_WR;
      frsa_pkg::S_NOFIT:   op_o = frsa_pkg::OP_NOFIT;
      frsa_pkg::S_INS_SET: op_o = frsa_pkg::OP_INS_SET;
      frsa_pkg::S_INS_CHK: if (sts_i.ins_more) op_o = frsa_pkg::OP_INS_RD;
      frsa_pkg::S_INS_MV:  op_o = frsa_pkg::OP_INS_MV;
      frsa_pkg::S_INS_WR:  op_o = frsa_pkg::OP_INS_WR;
      frsa_pkg::S_RM_SET:  op_o = frsa_pkg::OP_RM_SET;
      frsa_pkg::S_RM_CHK:  if (sts_i.rm_more) op_o = frsa_pkg::OP_RM_RD;
      frsa_pkg::S_RM_MV:   op_o = frsa_pkg::OP_RM_MV;
      frsa_pkg::S_FR_CHK:  if (sts_i.srch_open) op_o = frsa_pkg::OP_FR_RD;
      frsa_pkg::S_FR_CMP:  op_o = frsa_pkg::OP_FR_CMP;
      frsa_pkg::S_FR_L:    if (sts_i.has_left) op_o = frsa_pkg::OP_FR_LRD;
      frsa_pkg::S_FR_LE:   op_o = frsa_pkg::OP_FR_LEV;
      frsa_pkg::S_FR_R:    if (sts_i.has_right) op_o = frsa_pkg::OP_FR_RRD;
      frsa_pkg::S_FR_RE:   op_o = frsa_pkg::OP_FR_REV;
      frsa_pkg::S_FR_ACT: begin
        if (sts_i.adj_l) op_o = frsa_pkg::OP_FR_ML;
        else if (sts_i.adj_r) op_o = frsa_pkg::OP_FR_ADJR;
      end
      frsa_pkg::S_FR_ML:   op_o = frsa_pkg::OP_FR_MR;
      frsa_pkg::S_FR_MR:   op_o = frsa_pkg::OP_NONE;
      frsa_pkg::S_FR_MW:   op_o = frsa_pkg::OP_FR_MW;
      frsa_pkg::S_FIN:     if (sts_i.count_one) op_o = frsa_pkg::OP_FIN_RD;
      frsa_pkg::S_FIN_E:   op_o = frsa_pkg::OP_FIN_EV;
      frsa_pkg::S_DONE:    if (sts_i.out_free) op_o = frsa_pkg::OP_PUSH;
      default:             op_o = frsa_pkg::OP_NONE;
    endcase
    // left merge: add freed size first, right length in the following cycle
    if (state_q == frsa_pkg::S_FR_ACT && sts_i.adj_l) op_o = frsa_pkg::OP_FR_ML;
  end

endmodule

[design/frsa_dpath.sv]
// ----------------------------------------------------------------------------
// frsa_dpath
// Range table memory, scan and search registers, and the result register.
// ----------------------------------------------------------------------------
`include "free_range_suballocator_assert.svh"

module frsa_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  frsa_pkg::op_e                   op_i,
  output frsa_pkg::sts_t                  sts_o,
  input  logic                            func_i,
  input  logic [frsa_pkg::OFS_W-1:0]      size_i,
  input  logic [frsa_pkg::ALIGN_W-1:0]    align_i,
  input  logic [frsa_pkg::OFS_W-1:0]      offset_i,
  input  logic                            cfg_we_i,
  input  logic [frsa_pkg::OFS_W-1:0]      cfg_data_i,
  output logic [frsa_pkg::OFS_W-1:0]      chunk_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [frsa_pkg::STATUS_W-1:0]   out_status_o,
  output logic [frsa_pkg::OFS_W-1:0]      out_offset_o,
  output logic                            out_empty_o
);

  localparam int W  = frsa_pkg::OFS_W;
  localparam int CW = frsa_pkg::CNT_W;
  localparam int IW = frsa_pkg::IDX_W;

  frsa_pkg::range_t mem_q [frsa_pkg::MAX_RANGES];
  frsa_pkg::range_t rd_q, rdata, wdata;
  logic             we;
  logic [IW-1:0]    waddr, raddr;
  logic             rd_init0_q;

  // control
  logic [W-1:0]  chunk_q;
  logic [CW-1:0] count_q, i_q, pick_q, lo_q, hi_q, j_q, pos_q;
  logic          init0_q, found_q, adj_l_q, adj_r_q, ovf_q, nofit_q;
  logic          out_valid_q;
  // payload
  logic          func_q, empty_q;
  logic [frsa_pkg::ALIGN_W-1:0] k_q;
  logic [W-1:0]  size_q, off_q, st_q, len_q, pick_st_q, pick_len_q;
  logic [W:0]    en_q, a_q, tail_q;
  logic [W-1:0]  l_q, r_q, granted_q, ins_st_q, ins_len_q;
  logic [W-1:0]  left_st_q, left_len_q, right_len_q, merge_q;
  logic [frsa_pkg::STATUS_W-1:0] out_status_q;
  logic [W-1:0]  out_offset_q;
  logic          out_empty_q;

  logic [W:0]    am1, align_a, align_base;
  logic          fit, exact, better;
  logic [CW-1:0] mid, jm1, jp1, lom1, pickp1;
  logic [CW:0]   lohi;

  // aligned start of whichever range is being looked at
  always_comb begin
    am1        = ({{W{1'b0}}, 1'b1} << k_q) - {{W{1'b0}}, 1'b1};
    align_base = (op_i == frsa_pkg::OP_SP_A) ? {1'b0, pick_st_q} : {1'b0, rdata.start};
    align_a    = (align_base + am1) & ~am1;
  end

  assign rdata  = rd_init0_q ? '{start: '0, len: chunk_q} : rd_q;
  assign lohi   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = lohi[CW:1];
  assign jm1    = j_q - CW'(1);
  assign jp1    = j_q + CW'(1);
  assign lom1   = lo_q - CW'(1);
  assign pickp1 = pick_q + CW'(1);

  assign fit    = (a_q <= en_q) && ((en_q - a_q) >= {1'b0, size_q});
  assign exact  = len_q == size_q;
  assign better = !found_q || (len_q > pick_len_q);

  // table read and write addressing
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = '0;
    unique case (op_i)
      frsa_pkg::OP_AL_RD:  raddr = i_q[IW-1:0];
      frsa_pkg::OP_INS_RD: raddr = jm1[IW-1:0];
      frsa_pkg::OP_RM_RD:  raddr = jp1[IW-1:0];
      frsa_pkg::OP_FR_RD:  raddr = mid[IW-1:0];
      frsa_pkg::OP_FR_LRD: raddr = lom1[IW-1:0];
      frsa_pkg::OP_FR_RRD: raddr = lo_q[IW-1:0];
      frsa_pkg::OP_SP_WR: begin
        we    = l_q != '0 || r_q != '0;
        waddr = pick_q[IW-1:0];
        wdata = (l_q != '0) ? '{start: pick_st_q, len: l_q}
                            : '{start: tail_q[W-1:0], len: r_q};
      end
      frsa_pkg::OP_INS_MV, frsa_pkg::OP_RM_MV: begin
        we    = 1'b1;
        waddr = j_q[IW-1:0];
      end
      frsa_pkg::OP_INS_WR: begin
        we    = 1'b1;
        waddr = pos_q[IW-1:0];
        wdata = '{start: ins_st_q, len: ins_len_q};
      end
      frsa_pkg::OP_FR_ADJR: begin
        we    = 1'b1;
        waddr = lo_q[IW-1:0];
        wdata = '{start: off_q, len: right_len_q + size_q};
      end
      frsa_pkg::OP_FR_MW: begin
        we    = 1'b1;
        waddr = lom1[IW-1:0];
        wdata = '{start: left_st_q, len: merge_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q     <= frsa_pkg::CHUNK_RESET;
      count_q     <= CW'(1);
      init0_q     <= 1'b1;
      rd_init0_q  <= 1'b0;
      i_q         <= '0;
      pick_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      j_q         <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      adj_l_q     <= 1'b0;
      adj_r_q     <= 1'b0;
      ovf_q       <= 1'b0;
      nofit_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_init0_q <= init0_q && (raddr == '0);
      if (we && waddr == '0) init0_q <= 1'b0;
      if (cfg_we_i) begin
        chunk_q <= cfg_data_i;
        count_q <= CW'(1);
        init0_q <= 1'b1;
      end
      if (op_i == frsa_pkg::OP_PUSH) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (op_i)
        frsa_pkg::OP_LATCH: begin
          i_q     <= '0;
          found_q <= 1'b0;
          lo_q    <= '0;
          hi_q    <= count_q;
          adj_l_q <= 1'b0;
          adj_r_q <= 1'b0;
          ovf_q   <= 1'b0;
          nofit_q <= 1'b0;
        end
        frsa_pkg::OP_AL_EV2: begin
          if (fit && (exact || better)) begin
            pick_q  <= i_q;
            found_q <= 1'b1;
          end
          i_q <= i_q + CW'(1);
        end
        frsa_pkg::OP_NOFIT:  nofit_q <= 1'b1;
        frsa_pkg::OP_INS_SET: begin
          if (count_q >= CW'(frsa_pkg::MAX_RANGES)) ovf_q <= 1'b1;
          pos_q <= func_q ? lo_q : pickp1;
          j_q   <= count_q;
        end
        frsa_pkg::OP_INS_MV: j_q <= jm1;
        frsa_pkg::OP_INS_WR: count_q <= count_q + CW'(1);
        frsa_pkg::OP_RM_SET: begin
          j_q     <= func_q ? lo_q : pick_q;
          count_q <= count_q - CW'(1);
        end
        frsa_pkg::OP_RM_MV:  j_q <= jp1;
        frsa_pkg::OP_FR_CMP: begin
          if (rdata.start > off_q) hi_q <= mid;
          else lo_q <= mid + CW'(1);
        end
        frsa_pkg::OP_FR_LEV: adj_l_q <= (rdata.start + rdata.len) == off_q;
        frsa_pkg::OP_FR_REV: adj_r_q <= rdata.start == (off_q + size_q);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      frsa_pkg::OP_LATCH: begin
        func_q    <= func_i;
        size_q    <= size_i;
        k_q       <= align_i;
        off_q     <= offset_i;
        granted_q <= '0;
        empty_q   <= 1'b0;
      end
      frsa_pkg::OP_AL_EV1: begin
        st_q  <= rdata.start;
        len_q <= rdata.len;
        en_q  <= {1'b0, rdata.start} + {1'b0, rdata.len};
        a_q   <= align_a;
      end
      frsa_pkg::OP_AL_EV2: begin
        if (fit && (exact || better)) begin
          pick_st_q  <= st_q;
          pick_len_q <= len_q;
        end
      end
      frsa_pkg::OP_SP_A: begin
        en_q <= {1'b0, pick_st_q} + {1'b0, pick_len_q};
        a_q  <= align_a;
      end
      frsa_pkg::OP_SP_B: begin
        tail_q <= a_q + {1'b0, size_q};
        l_q    <= a_q[W-1:0] - pick_st_q;
      end
      frsa_pkg::OP_SP_C: begin
        r_q       <= en_q[W-1:0] - tail_q[W-1:0];
        granted_q <= a_q[W-1:0];
      end
      frsa_pkg::OP_INS_SET: begin
        ins_st_q  <= func_q ? off_q : tail_q[W-1:0];
        ins_len_q <= func_q ? size_q : r_q;
      end
      frsa_pkg::OP_FR_LEV: begin
        left_st_q  <= rdata.start;
        left_len_q <= rdata.len;
      end
      frsa_pkg::OP_FR_REV: right_len_q <= rdata.len;
      frsa_pkg::OP_FR_ML:  merge_q <= left_len_q + size_q;
      frsa_pkg::OP_FR_MR:  if (adj_r_q) merge_q <= merge_q + right_len_q;
      frsa_pkg::OP_FIN_EV: empty_q <= (rdata.start == '0) && (rdata.len == chunk_q);
      frsa_pkg::OP_PUSH: begin
        out_status_q <= ovf_q ? frsa_pkg::ST_OVERFLOW :
                        nofit_q ? frsa_pkg::ST_NOMEM : frsa_pkg::ST_OK;
        out_offset_q <= nofit_q ? '0 : granted_q;
        out_empty_q  <= empty_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o           = '0;
    sts_o.is_free   = func_q;
    sts_o.scan_end  = i_q >= count_q;
    sts_o.found     = found_q;
    sts_o.fit_exact = fit && exact;
    sts_o.l_nz      = l_q != '0;
    sts_o.r_nz      = r_q != '0;
    sts_o.full      = count_q >= CW'(frsa_pkg::MAX_RANGES);
    sts_o.ins_more  = j_q > pos_q;
    sts_o.rm_more   = j_q < count_q;
    sts_o.srch_open = lo_q < hi_q;
    sts_o.has_left  = lo_q != '0;
    sts_o.has_right = lo_q < count_q;
    sts_o.adj_l     = adj_l_q;
    sts_o.adj_r     = adj_r_q;
    sts_o.count_one = count_q == CW'(1);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign chunk_o      = chunk_q;
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_offset_o = out_offset_q;
  assign out_empty_o  = out_empty_q;

  `FRSA_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(frsa_pkg::MAX_RANGES))
  `FRSA_ASSERT_IMP(a_one_error, clk_i, rst_ni, 1'b1, !(ovf_q && nofit_q))
  `FRSA_ASSERT_IMP(a_ins_room, clk_i, rst_ni, op_i == frsa_pkg::OP_INS_WR, count_q < CW'(frsa_pkg::MAX_RANGES))
  `FRSA_ASSERT_IMP(a_rm_nonempty, clk_i, rst_ni, op_i == frsa_pkg::OP_RM_SET, count_q != '0)
  `FRSA_ASSERT_NXT(a_ins_grow, clk_i, rst_ni, op_i == frsa_pkg::OP_INS_WR, count_q == $past(count_q) + CW'(1))

endmodule

[dv/tb_free_range_suballocator.sv]
// ----------------------------------------------------------------------------
// tb_free_range_suballocator
// Self-checking bench: drives allocate/free requests through the stream port,
// tracks the free-range table in a local model and compares every result.
// ----------------------------------------------------------------------------
module tb_free_range_suballocator;

  localparam int LIMIT_CYCLES = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [71:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  free_range_suballocator DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Laid out as m_axis_tdata: status lowest, then offset, then empty
  typedef struct packed {
    logic        empty;
    logic [31:0] offset;
    logic [1:0]  status;
  } grant_t;

  typedef struct {
    logic        is_free;
    logic [31:0] size;
    logic [4:0]  align;
    logic [31:0] offs;
    logic        has_exp;
    grant_t      exp;
  } req_row_t;

  // Local copy of the range table
  logic [31:0] tbl_start [frsa_pkg::MAX_RANGES];
  logic [31:0] tbl_len   [frsa_pkg::MAX_RANGES];
  int          tbl_count;
  logic [31:0] chunk_bytes;

  grant_t      pending_grants[$];
  int          err_count = 0;
  longint      cycle_count = 0;
  bit          sink_enable = 1'b0;
  // Live allocations, used to build plausible frees
  logic [31:0] held_off[$];
  logic [31:0] held_size[$];

  function automatic void table_reset();
    tbl_count = 1;
    tbl_start[0] = '0;
    tbl_len[0] = chunk_bytes;
  endfunction

  function automatic bit table_insert(int pos, logic [31:0] st, logic [31:0] ln);
    if (tbl_count >= frsa_pkg::MAX_RANGES || pos > tbl_count) return 1'b0;
    for (int i = tbl_count; i > pos; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_len[i] = tbl_len[i-1];
    end
    tbl_start[pos] = st;
    tbl_len[pos] = ln;
    tbl_count++;
    return 1'b1;
  endfunction

  function automatic void table_remove(int pos);
    if (tbl_count == 0 || pos >= tbl_count) return;
    tbl_count--;
    for (int i = pos; i < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_len[i] = tbl_len[i+1];
    end
  endfunction

  // Advance the table by one request and return the grant it produces.
  function automatic grant_t table_apply(logic is_free, logic [31:0] size,
                                         logic [4:0] align, logic [31:0] offs);
    grant_t            g;
    logic [32:0]       am1, st, en, a, tl, l, r;
    int                pick, lo, hi, mid;
    bit                found, adj_l, adj_r;
    frsa_pkg::status_e st_code;
    g = '0;
    st_code = frsa_pkg::ST_OK;
    if (!is_free) begin
      am1 = (33'd1 << align) - 33'd1;
      found = 1'b0;
      pick = 0;
      for (int i = 0; i < tbl_count; i++) begin
        st = {1'b0, tbl_start[i]};
        en = st + tbl_len[i];
        a = (st + am1) & ~am1;
        if (a > en || en - a < size) continue;
        if (tbl_len[i] == size) begin
          pick = i;
          found = 1'b1;
          break;
        end
        if (!found || tbl_len[i] > tbl_len[pick]) begin
          pick = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        st_code = frsa_pkg::ST_NOMEM;
      end else begin
        st = {1'b0, tbl_start[pick]};
        en = st + tbl_len[pick];
        a = (st + am1) & ~am1;
        tl = a + size;
        l = a - st;
        r = en - tl;
        g.offset = a[31:0];
        if (l != 0) begin
          tbl_len[pick] = l[31:0];
          if (r != 0 && !table_insert(pick + 1, tl[31:0], r[31:0]))
            st_code = frsa_pkg::ST_OVERFLOW;
        end else if (r != 0) begin
          tbl_start[pick] = tl[31:0];
          tbl_len[pick] = r[31:0];
        end else begin
          table_remove(pick);
        end
      end
    end else begin
      // binary search for the first range starting above the freed offset
      lo = 0;
      hi = tbl_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tbl_start[mid] > offs) hi = mid;
        else lo = mid + 1;
      end
      adj_l = (lo > 0) && (tbl_start[lo-1] + tbl_len[lo-1] == offs);
      adj_r = (lo < tbl_count) && (tbl_start[lo] == offs + size);
      if (adj_l) begin
        tbl_len[lo-1] = tbl_len[lo-1] + size;
        if (adj_r) begin
          tbl_len[lo-1] = tbl_len[lo-1] + tbl_len[lo];
          table_remove(lo);
        end
      end else if (adj_r) begin
        tbl_start[lo] = offs;
        tbl_len[lo] = tbl_len[lo] + size;
      end else if (!table_insert(lo, offs, size)) begin
        st_code = frsa_pkg::ST_OVERFLOW;
      end
    end
    g.status = st_code;
    g.empty = (tbl_count == 1 && tbl_start[0] == 0 && tbl_len[0] == chunk_bytes);
    return g;
  endfunction

  task automatic apb_write(logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    chunk_bytes = val;
    table_reset();
    held_off.delete();
    held_size.delete();
  endtask

  // Offer one request, hold valid until taken, then queue its grant.
  task automatic send_request(req_row_t rq);
    grant_t g;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= rq.is_free;
    s_axis_tdata <= {3'b0, rq.offs, rq.align, rq.size};
    do @(posedge clk_i); while (!s_axis_tready);
    g = table_apply(rq.is_free, rq.size, rq.align, rq.offs);
    if (rq.has_exp && g !== rq.exp) begin
      $error("directed row: expected %h, actual %h", rq.exp, g);
      err_count++;
    end
    pending_grants.push_back(rq.has_exp ? rq.exp : g);
    if (!rq.is_free && g.status != frsa_pkg::ST_NOMEM) begin
      held_off.push_back(g.offset);
      held_size.push_back(rq.size);
    end
  endtask

  // Random gap after a request, usually none, sometimes long.
  task automatic sender_gap(ref int burst_left);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 200)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic wait_drain();
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Receiver: stall pattern of its own, with stall-free stretches.
  always @(posedge clk_i) begin
    if (!sink_enable) m_axis_tready <= 1'b0;
    else if ((cycle_count / 3000) % 4 == 1) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) < 60);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    grant_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[34:0];
      if (pending_grants.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        err_count++;
      end else begin
        want = pending_grants.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          err_count++;
        end
        if (got.offset !== want.offset) begin
          $error("alloc_offset: expected %h, actual %h", want.offset, got.offset);
          err_count++;
        end
        if (got.empty !== want.empty) begin
          $error("chunk_empty: expected %0d, actual %0d", want.empty, got.empty);
          err_count++;
        end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_row_t mk(logic f, logic [31:0] sz, logic [4:0] al,
                                  logic [31:0] of);
    req_row_t rq;
    rq.is_free = f;
    rq.size = sz;
    rq.align = al;
    rq.offs = of;
    rq.has_exp = 1'b0;
    rq.exp = '0;
    return rq;
  endfunction

  function automatic req_row_t mk_exp(logic f, logic [31:0] sz, logic [4:0] al,
                                      logic [31:0] of, frsa_pkg::status_e s,
                                      logic [31:0] o, logic e);
    req_row_t rq;
    rq = mk(f, sz, al, of);
    rq.has_exp = 1'b1;
    rq.exp = '{status: s, offset: o, empty: e};
    return rq;
  endfunction

  initial begin
    req_row_t plan[$];
    req_row_t rq;
    int       burst_left, pick, phase_items, kind;
    logic [31:0] sizes [4];

    chunk_bytes = frsa_pkg::CHUNK_RESET;
    table_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sink_enable = 1'b1;

    // Directed table against the reset chunk of 16 MiB
    plan.push_back(mk_exp(1'b0, 32'h0100_0000, 5'd0, 32'hFFFF_FFFF, frsa_pkg::ST_OK,
                          32'h0, 1'b0));
    plan.push_back(mk_exp(1'b0, 32'd1, 5'd0, 32'h0, frsa_pkg::ST_NOMEM,
                          32'h0, 1'b0));                                       // empty table
    plan.push_back(mk_exp(1'b1, 32'h0100_0000, 5'd31, 32'h0, frsa_pkg::ST_OK,
                          32'h0, 1'b1));
    plan.push_back(mk_exp(1'b0, 32'hFFFF_FFFF, 5'd0, 32'h0, frsa_pkg::ST_NOMEM,
                          32'h0, 1'b1));
    plan.push_back(mk_exp(1'b0, 32'd1, 5'd31, 32'h0, frsa_pkg::ST_OK,
                          32'h0, 1'b0));                                       // align max
    plan.push_back(mk_exp(1'b0, 32'd16, 5'd4, 32'h0, frsa_pkg::ST_OK,
                          32'h10, 1'b0));                                      // leading gap
    plan.push_back(mk(1'b0, 32'd0, 5'd0, 32'h0));                              // zero size
    plan.push_back(mk_exp(1'b0, 32'd1, 5'd24, 32'h0, frsa_pkg::ST_NOMEM,
                          32'h0, 1'b0));                                       // past end
    plan.push_back(mk(1'b1, 32'd16, 5'd0, 32'h10));                            // merge
    plan.push_back(mk(1'b1, 32'd0, 5'd0, 32'h0080_0000));                      // zero free
    plan.push_back(mk(1'b1, 32'd1, 5'd0, 32'h0));
    plan.push_back(mk(1'b1, 32'd8, 5'd0, 32'hFFFF_FFF8));                      // wrap sum
    plan.push_back(mk(1'b1, 32'hFFFF_FFFF, 5'd0, 32'h0000_0100));              // overlap
    plan.push_back(mk(1'b0, 32'h5555_5555, 5'd10, 32'hAAAA_AAAA));
    plan.push_back(mk(1'b1, 32'hAAAA_AAAA, 5'd21, 32'h5555_5555));
    plan.push_back(mk(1'b0, 32'd3, 5'd1, 32'h0));
    burst_left = 0;
    foreach (plan[i]) begin
      send_request(plan[i]);
      sender_gap(burst_left);
    end
    s_axis_tvalid <= 1'b0;
    wait_drain();

    // Table overflow: tiny chunk, then many one-byte frees in disjoint spots
    apb_write(32'd4096);
    send_request(mk(1'b0, 32'd4096, 5'd0, 32'h0));
    for (int i = 0; i < frsa_pkg::MAX_RANGES + 4; i++) begin
      send_request(mk(1'b1, 32'd1, 5'd0, 32'(i * 8)));
      sender_gap(burst_left);
    end
    s_axis_tvalid <= 1'b0;
    wait_drain();

    // Random phases over several chunk sizes, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apb_write(32'd1);
        1: apb_write(32'hFFFF_FFFF);
        2: apb_write(32'd65536);
        3: apb_write($urandom_range(100, 5000));
        4: apb_write($urandom());
        default: apb_write(frsa_pkg::CHUNK_RESET);
      endcase
      sizes = '{1, 16, 256, 4096};
      phase_items = (ph == 0) ? 60 : 270;
      for (int n = 0; n < phase_items; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          rq = mk(1'b0, sizes[$urandom_range(0, 3)] + $urandom_range(0, 40),
                  5'($urandom_range(0, 6)), $urandom());
          if (kind < 3) rq.size = $urandom();
          if (kind == 3) rq.align = 5'($urandom_range(0, 31));
          if (ph == 1 && kind < 10) rq.size = 32'h1000_0000 + $urandom_range(0, 255);
        end else if (kind < 90 && held_off.size() != 0) begin
          pick = $urandom_range(0, held_off.size() - 1);
          rq = mk(1'b1, held_size[pick], 5'($urandom_range(0, 31)), held_off[pick]);
          held_off.delete(pick);
          held_size.delete(pick);
        end else begin
          // noise: arbitrary free, possibly overlapping or outside the chunk
          rq = mk(1'b1, $urandom_range(0, 64), 5'($urandom()), $urandom());
          if (kind > 96) rq.size = $urandom();
        end
        send_request(rq);
        sender_gap(burst_left);
      end
      s_axis_tvalid <= 1'b0;
      wait_drain();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
